// ===== hdl/lfur_pkg.sv =====
`default_nettype none
package lfur_pkg;

  // Bits per table entry and per draw
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned BIT_CNT_W = 5;
  // Short lag starts at the 33rd entry
  localparam int unsigned SHORT_LAG_ADDR = 32;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_SEED_LOAD,
    CS_SEED_DIV,
    CS_SEED_SPLIT,
    CS_MIX,
    CS_FILL_END,
    CS_DRAW_READ,
    CS_DRAW_DIFF,
    CS_DRAW_SCALE,
    CS_RESULT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MX_AB,
    MX_RED1,
    MX_FIX1,
    MX_XC,
    MX_RED2,
    MX_FIX2,
    MX_BIT
  } mix_phase_e;

  typedef enum logic [1:0] {
    CFG_SEED_FIRST,
    CFG_SEED_SECOND,
    CFG_RANGE_LOWER,
    CFG_RANGE_UPPER
  } cfg_reg_e;

  typedef struct packed {
    logic       seed_load;
    logic       seed_div;
    logic       seed_split;
    logic       mix_en;
    mix_phase_e mix_phase;
    logic       fill_we;
    logic       fill_end;
    logic       draw_read;
    logic       draw_diff;
    logic       draw_scale;
    logic       result_load;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/lfur_ram.sv =====
`default_nettype none
module lfur_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 97,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule
`default_nettype wire

// ===== hdl/lfur_ctrl.sv =====
`default_nettype none
module lfur_ctrl #(
  parameter int unsigned TABLE_DEPTH = 97,
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              reseed_i,
  input  wire logic              out_free_i,
  output lfur_pkg::dp_cmd_t      cmd_o,
  output logic      [ADDR_W-1:0] fill_addr_o
);

  import lfur_pkg::*;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAC_W - 1);
  localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_DEPTH - 1);

  ctrl_state_e            state_q, state_d;
  mix_phase_e             phase_q, phase_d;
  logic [BIT_CNT_W-1:0]   bit_q, bit_d;
  logic [ADDR_W-1:0]      entry_q, entry_d;
  logic                   seed_busy_q, seed_busy_d;
  logic                   entry_done;

  assign entry_done = (phase_q == MX_BIT) && (bit_q == LAST_BIT);

  // Next state and sequencing counters
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    bit_d       = bit_q;
    entry_d     = entry_q;
    seed_busy_d = seed_busy_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          // the first request after reset always rebuilds the table
          state_d = (reseed_i || seed_busy_q) ? CS_SEED_LOAD : CS_DRAW_READ;
        end
      end
      CS_SEED_LOAD:  state_d = CS_SEED_DIV;
      CS_SEED_DIV:   state_d = CS_SEED_SPLIT;
      CS_SEED_SPLIT: begin
        state_d = CS_MIX;
        phase_d = MX_AB;
        bit_d   = '0;
        entry_d = '0;
      end
      CS_MIX: begin
        unique case (phase_q)
          MX_AB:   phase_d = MX_RED1;
          MX_RED1: phase_d = MX_FIX1;
          MX_FIX1: phase_d = MX_XC;
          MX_XC:   phase_d = MX_RED2;
          MX_RED2: phase_d = MX_FIX2;
          MX_FIX2: phase_d = MX_BIT;
          MX_BIT:  phase_d = MX_AB;
          default: phase_d = MX_AB;
        endcase
        if (phase_q == MX_BIT) begin
          bit_d = entry_done ? '0 : bit_q + 1'b1;
        end
        if (entry_done) begin
          if (entry_q == LAST_ENTRY) begin
            state_d = CS_FILL_END;
          end else begin
            entry_d = entry_q + 1'b1;
          end
        end
      end
      CS_FILL_END: begin
        state_d     = CS_DRAW_READ;
        seed_busy_d = 1'b0;
      end
      CS_DRAW_READ:  state_d = CS_DRAW_DIFF;
      CS_DRAW_DIFF:  state_d = CS_DRAW_SCALE;
      CS_DRAW_SCALE: state_d = CS_RESULT;
      CS_RESULT: begin
        // hold the result until the output register is free
        if (out_free_i) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.mix_phase = phase_q;
    in_ready_o      = 1'b0;
    unique case (state_q)
      CS_IDLE:       in_ready_o = 1'b1;
      CS_SEED_LOAD:  cmd_o.seed_load = 1'b1;
      CS_SEED_DIV:   cmd_o.seed_div = 1'b1;
      CS_SEED_SPLIT: cmd_o.seed_split = 1'b1;
      CS_MIX: begin
        cmd_o.mix_en  = 1'b1;
        cmd_o.fill_we = entry_done;
      end
      CS_FILL_END:   cmd_o.fill_end = 1'b1;
      CS_DRAW_READ:  cmd_o.draw_read = 1'b1;
      CS_DRAW_DIFF:  cmd_o.draw_diff = 1'b1;
      CS_DRAW_SCALE: cmd_o.draw_scale = 1'b1;
      CS_RESULT:     cmd_o.result_load = out_free_i;
      default:       in_ready_o = 1'b0;
    endcase
  end

  assign fill_addr_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      phase_q     <= MX_AB;
      bit_q       <= '0;
      entry_q     <= '0;
      seed_busy_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      entry_q     <= entry_d;
      seed_busy_q <= seed_busy_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lfur_dp.sv =====
`default_nettype none
module lfur_dp #(
  parameter int unsigned TABLE_DEPTH = 97,
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lfur_pkg::dp_cmd_t  cmd_i,
  input  wire logic [ADDR_W-1:0]  fill_addr_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic      [23:0]        uniform_fraction_o,
  output logic signed [31:0]      scaled_integer_o,
  output logic                    out_free_o
);

  import lfur_pkg::*;

  localparam logic [14:0] SEED1_MAX = 15'd31328;
  localparam logic [14:0] SEED2_MAX = 15'd30081;
  localparam logic [14:0] SEED1_DEFAULT = 15'd1802;
  localparam logic [14:0] SEED2_DEFAULT = 15'd9373;
  // floor(2^22 / m): the estimate is at most one short, fixed by one subtract
  localparam logic [29:0] RECIP177 = 30'd23696;
  localparam logic [29:0] RECIP169 = 30'd24818;
  localparam logic [29:0] RECIP179 = 30'd23431;
  localparam logic [15:0] MOD177 = 16'd177;
  localparam logic [15:0] MOD169 = 16'd169;
  localparam logic [15:0] MOD179 = 16'd179;
  localparam logic [FRAC_W-1:0] CARRY_INIT = 24'd362436;
  localparam logic [FRAC_W-1:0] CARRY_DEC = 24'd7654321;
  localparam logic [FRAC_W-1:0] CARRY_WRAP = 24'd9122892;  // modulus minus step
  localparam logic [FRAC_W-1:0] FRAC_ONE = '1;
  localparam logic [ADDR_W-1:0] LONG_START = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] SHORT_START = ADDR_W'(SHORT_LAG_ADDR);

  function automatic logic [7:0] rem_fix(input logic [15:0] num, input logic [7:0] q_est,
                                         input logic [15:0] modulus);
    logic [15:0] r0;
    r0 = num - 16'(q_est) * modulus;
    if (r0 >= modulus) begin
      r0 = r0 - modulus;
    end
    return r0[7:0];
  endfunction

  // Configuration registers
  logic [14:0]        seed_first_q, seed_first_d;
  logic [14:0]        seed_second_q, seed_second_d;
  logic signed [31:0] range_lower_q, range_lower_d;
  logic signed [31:0] range_upper_q, range_upper_d;

  // Seeding datapath
  logic [14:0] s1_q, s1_d, s2_q, s2_d;
  logic [29:0] tm_a_q, tm_a_d, tm_b_q, tm_b_d;
  logic [15:0] prod_a_q, prod_a_d;
  logic [13:0] prod_b_q, prod_b_d;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, x_q, x_d;
  logic [FRAC_W-1:0] v_q, v_d;

  // Draw datapath
  logic [ADDR_W-1:0] long_q, long_d, short_q, short_d;
  logic [FRAC_W-1:0] carry_q, carry_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [32:0]       span_mag_q, span_mag_d;
  logic              span_neg_q, span_neg_d;
  logic [56:0]       scale_q, scale_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [FRAC_W-1:0]  out_frac_q, out_frac_d;
  logic signed [31:0] out_int_q, out_int_d;

  // Table port
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic [FRAC_W-1:0] tbl_wdata;
  logic [FRAC_W-1:0] rd_long, rd_short;

  // Combinational helpers
  logic [15:0]       r1_raw, r2_raw;
  logic              r1_fix, r2_fix;
  logic [7:0]        q1_est, q2_est;
  logic [5:0]        bit_prod;
  logic              mix_bit;
  logic [FRAC_W-1:0] diff;
  logic signed [33:0] span;
  logic [31:0]       q_low;

  assign q1_est = tm_a_q[29:22];
  assign q2_est = tm_b_q[29:22];
  assign r1_raw = 16'(s1_q) - 16'(q1_est) * MOD177;
  assign r2_raw = 16'(s2_q) - 16'(q2_est) * MOD169;
  assign r1_fix = (r1_raw >= MOD177);
  assign r2_fix = (r2_raw >= MOD169);

  // output bit: (d * m) mod 64 >= 32
  assign bit_prod = d_q[5:0] * c_q[5:0];
  assign mix_bit  = bit_prod[5];

  assign diff  = rd_long - rd_short;
  assign span  = 34'(range_upper_q) - 34'(range_lower_q) + 34'sd1;
  assign q_low = scale_q[55:24];

  always_comb begin
    seed_first_d  = seed_first_q;
    seed_second_d = seed_second_q;
    range_lower_d = range_lower_q;
    range_upper_d = range_upper_q;
    s1_d = s1_q;
    s2_d = s2_q;
    tm_a_d = tm_a_q;
    tm_b_d = tm_b_q;
    prod_a_d = prod_a_q;
    prod_b_d = prod_b_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    x_d = x_q;
    v_d = v_q;
    long_d = long_q;
    short_d = short_q;
    carry_d = carry_q;
    frac_d = frac_q;
    span_mag_d = span_mag_q;
    span_neg_d = span_neg_q;
    scale_d = scale_q;
    out_frac_d = out_frac_q;
    out_int_d = out_int_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SEED_FIRST:  seed_first_d  = cfg_data_i[14:0];
        CFG_SEED_SECOND: seed_second_d = cfg_data_i[14:0];
        CFG_RANGE_LOWER: range_lower_d = cfg_data_i;
        CFG_RANGE_UPPER: range_upper_d = cfg_data_i;
        default: ;
      endcase
    end

    // Seed set-up: replace illegal seeds, then split by 177 and 169
    if (cmd_i.seed_load) begin
      s1_d = (seed_first_q > SEED1_MAX) ? SEED1_DEFAULT : seed_first_q;
      s2_d = (seed_second_q > SEED2_MAX) ? SEED2_DEFAULT : seed_second_q;
    end
    if (cmd_i.seed_div) begin
      tm_a_d = 30'(s1_q) * RECIP177;
      tm_b_d = 30'(s2_q) * RECIP169;
    end
    if (cmd_i.seed_split) begin
      a_d = q1_est + 8'(r1_fix) + 8'd2;
      b_d = (r1_fix ? 8'(r1_raw - MOD177) : r1_raw[7:0]) + 8'd2;
      c_d = q2_est + 8'(r2_fix) + 8'd1;
      d_d = r2_fix ? 8'(r2_raw - MOD169) : r2_raw[7:0];
    end

    if (cmd_i.mix_en) begin
      unique case (cmd_i.mix_phase)
        MX_AB: begin
          prod_a_d = 16'(a_q) * 16'(b_q);
          prod_b_d = 14'(14'(d_q) * 14'd53 + 14'd1);
        end
        MX_RED1: begin
          tm_a_d = 30'(prod_a_q) * RECIP179;
          tm_b_d = 30'(prod_b_q) * RECIP169;
        end
        MX_FIX1: begin
          x_d = rem_fix(prod_a_q, tm_a_q[29:22], MOD179);
          d_d = rem_fix(16'(prod_b_q), tm_b_q[29:22], MOD169);
        end
        MX_XC:   prod_a_d = 16'(x_q) * 16'(c_q);
        MX_RED2: tm_a_d = 30'(prod_a_q) * RECIP179;
        MX_FIX2: begin
          a_d = b_q;
          b_d = c_q;
          c_d = rem_fix(prod_a_q, tm_a_q[29:22], MOD179);
        end
        MX_BIT:  v_d = {v_q[FRAC_W-2:0], mix_bit};
        default: ;
      endcase
    end

    if (cmd_i.fill_end) begin
      long_d  = LONG_START;
      short_d = SHORT_START;
      carry_d = CARRY_INIT;
    end

    if (cmd_i.draw_read) begin
      carry_d    = (carry_q < CARRY_DEC) ? carry_q + CARRY_WRAP : carry_q - CARRY_DEC;
      span_neg_d = span[33];
      span_mag_d = span[33] ? 33'(-span) : span[32:0];
    end

    if (cmd_i.draw_diff) begin
      long_d  = (long_q == '0) ? LONG_START : long_q - 1'b1;
      short_d = (short_q == '0) ? LONG_START : short_q - 1'b1;
      // a zero difference with zero carry is a draw of exactly one: saturate
      frac_d  = (diff == '0 && carry_q == '0) ? FRAC_ONE : diff - carry_q;
    end

    if (cmd_i.draw_scale) begin
      scale_d = 57'(frac_q) * 57'(span_mag_q);
    end

    if (cmd_i.result_load) begin
      out_frac_d  = frac_q;
      out_int_d   = range_lower_q + (span_neg_q ? -q_low : q_low);
      out_valid_d = 1'b1;
    end
  end

  assign tbl_we    = cmd_i.fill_we || cmd_i.draw_diff;
  assign tbl_waddr = cmd_i.draw_diff ? long_q : fill_addr_i;
  assign tbl_wdata = cmd_i.draw_diff ? diff : {v_q[FRAC_W-2:0], mix_bit};

  lfur_ram #(
    .WIDTH(FRAC_W),
    .DEPTH(TABLE_DEPTH)
  ) u_lag_ram (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (tbl_waddr),
    .wdata_i   (tbl_wdata),
    .raddr_a_i (long_q),
    .raddr_b_i (short_q),
    .rdata_a_o (rd_long),
    .rdata_b_o (rd_short)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= SEED1_DEFAULT;
      seed_second_q <= SEED2_DEFAULT;
      range_lower_q <= 32'sd0;
      range_upper_q <= 32'sd1;
      long_q        <= LONG_START;
      short_q       <= SHORT_START;
      carry_q       <= CARRY_INIT;
      out_valid_q   <= 1'b0;
    end else begin
      seed_first_q  <= seed_first_d;
      seed_second_q <= seed_second_d;
      range_lower_q <= range_lower_d;
      range_upper_q <= range_upper_d;
      long_q        <= long_d;
      short_q       <= short_d;
      carry_q       <= carry_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= s1_d;
    s2_q       <= s2_d;
    tm_a_q     <= tm_a_d;
    tm_b_q     <= tm_b_d;
    prod_a_q   <= prod_a_d;
    prod_b_q   <= prod_b_d;
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    d_q        <= d_d;
    x_q        <= x_d;
    v_q        <= v_d;
    frac_q     <= frac_d;
    span_mag_q <= span_mag_d;
    span_neg_q <= span_neg_d;
    scale_q    <= scale_d;
    out_frac_q <= out_frac_d;
    out_int_q  <= out_int_d;
  end

  assign out_valid_o        = out_valid_q;
  assign uniform_fraction_o = out_frac_q;
  assign scaled_integer_o   = out_int_q;
  assign out_free_o         = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// ===== hdl/lagged_fibonacci_uniform_rng_unit.sv =====
`default_nettype none
// Lagged-Fibonacci (RANMAR) uniform generator in 24-bit fixed point. Each request
// returns one draw: uniform_fraction_o is the draw times 2^24 and scaled_integer_o
// is the draw scaled into the inclusive range [range_lower, range_upper]. A plain
// draw runs through the registered two-port table read, the subtract and the 24x33
// scaling multiply, and no new request is taken until its result is loaded. The
// first request after reset, and any request with reseed_i set, first rebuilds the
// 97-entry lag table from the seed registers with the mixing step (two mod-179
// multiply-reduce passes on one shared reducer) run 24 times per entry. Illegal
// seeds fall back to 1802 and 9373. A finished result waits in the output register
// while the next request is taken.
// Configuration registers: 0 seed_first, 1 seed_second, 2 range_lower,
// 3 range_upper; write them only while the block is idle.
module lagged_fibonacci_uniform_rng_unit #(
  parameter int unsigned TABLE_DEPTH = 97
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               reseed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [23:0]        uniform_fraction_o,
  output logic signed [31:0]      scaled_integer_o
);

  import lfur_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  dp_cmd_t           cmd;
  logic [ADDR_W-1:0] fill_addr;
  logic              out_free;

  assign cfg_ready_o = 1'b1;

  lfur_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .reseed_i    (reseed_i),
    .out_free_i  (out_free),
    .cmd_o       (cmd),
    .fill_addr_o (fill_addr)
  );

  lfur_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .fill_addr_i        (fill_addr),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .uniform_fraction_o (uniform_fraction_o),
    .scaled_integer_o   (scaled_integer_o),
    .out_free_o         (out_free)
  );

endmodule
`default_nettype wire

// ===== sim/lagged_fibonacci_uniform_rng_checker.sv =====
`timescale 1ns / 1ps
module lagged_fibonacci_uniform_rng_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               reseed_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [23:0]        uniform_fraction_i,
  input  wire logic signed [31:0] scaled_integer_i,
  output int                      mismatches_o,
  output int                      outstanding_o
);

  import lfur_pkg::*;

  localparam int unsigned LAG_DEPTH        = 97;
  localparam int unsigned SHORT_LAG_START  = 33;
  localparam int unsigned CARRY_START      = 362436;
  localparam int unsigned CARRY_STEP       = 7654321;
  localparam int unsigned CARRY_MODULUS    = 16777213;
  localparam int unsigned SEED_FIRST_MAX   = 31328;
  localparam int unsigned SEED_SECOND_MAX  = 30081;
  localparam int unsigned SEED_FIRST_DFLT  = 1802;
  localparam int unsigned SEED_SECOND_DFLT = 9373;

  typedef struct packed {
    logic [FRAC_W-1:0]  fraction;
    logic signed [31:0] scaled;
  } draw_t;

  logic [14:0]        seed_first_q;
  logic [14:0]        seed_second_q;
  logic signed [31:0] lower_q;
  logic signed [31:0] upper_q;

  logic [FRAC_W-1:0]  lag_mem [LAG_DEPTH];
  int unsigned        long_pos;
  int unsigned        short_pos;
  logic [FRAC_W-1:0]  carry_q;
  logic               table_stale;

  draw_t              draws_due [$];
  int                 errs = 0;

  // Mixing sequence: mod-179 lagged product plus mod-169 congruential, one bit per step
  function automatic void rebuild_table(input logic [14:0] s1_reg, input logic [14:0] s2_reg);
    int unsigned a, b, c, d, m, s1, s2;
    int unsigned n, k;
    logic [FRAC_W-1:0] v;
    s1 = s1_reg;
    s2 = s2_reg;
    if (s1 > SEED_FIRST_MAX) s1 = SEED_FIRST_DFLT;
    if (s2 > SEED_SECOND_MAX) s2 = SEED_SECOND_DFLT;
    a = (s1 / 177) % 177 + 2;
    b = s1 % 177 + 2;
    c = (s2 / 169) % 178 + 1;
    d = s2 % 169;
    for (n = 0; n < LAG_DEPTH; n++) begin
      v = '0;
      for (k = 0; k < FRAC_W; k++) begin
        m = (((a * b) % 179) * c) % 179;
        a = b;
        b = c;
        c = m;
        d = (53 * d + 1) % 169;
        v = {v[FRAC_W-2:0], ((d * m) % 64) >= 32};
      end
      lag_mem[n] = v;
    end
    long_pos    = LAG_DEPTH;
    short_pos   = SHORT_LAG_START;
    carry_q     = FRAC_W'(CARRY_START);
    table_stale = 1'b0;
  endfunction

  function automatic draw_t next_draw(input logic reseed);
    logic [FRAC_W-1:0] x, y, diff, frac;
    longint            lo, span, q, res;
    draw_t             r;
    if (reseed || table_stale) rebuild_table(seed_first_q, seed_second_q);
    x = lag_mem[long_pos - 1];
    y = lag_mem[short_pos - 1];
    diff = x - y;
    lag_mem[long_pos - 1] = diff;
    long_pos  = (long_pos <= 1) ? LAG_DEPTH : long_pos - 1;
    short_pos = (short_pos <= 1) ? LAG_DEPTH : short_pos - 1;
    if (carry_q < CARRY_STEP) carry_q = FRAC_W'(carry_q + (CARRY_MODULUS - CARRY_STEP));
    else carry_q = FRAC_W'(carry_q - CARRY_STEP);
    // a draw of exactly one saturates
    if (diff == '0 && carry_q == '0) frac = '1;
    else frac = diff - carry_q;
    lo   = lower_q;
    span = longint'(upper_q) - lo + 1;
    // truncate toward zero, whatever the sign of the span
    if (span >= 0) q = (longint'(frac) * span) >>> 24;
    else q = -((longint'(frac) * (-span)) >>> 24);
    res = lo + q;
    r.fraction = frac;
    r.scaled   = res[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      seed_first_q  = 15'(SEED_FIRST_DFLT);
      seed_second_q = 15'(SEED_SECOND_DFLT);
      lower_q       = 32'sd0;
      upper_q       = 32'sd1;
      long_pos      = LAG_DEPTH;
      short_pos     = SHORT_LAG_START;
      carry_q       = FRAC_W'(CARRY_START);
      table_stale   = 1'b1;
      draws_due.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SEED_FIRST:  seed_first_q  = cfg_data_i[14:0];
          CFG_SEED_SECOND: seed_second_q = cfg_data_i[14:0];
          CFG_RANGE_LOWER: lower_q       = cfg_data_i;
          CFG_RANGE_UPPER: upper_q       = cfg_data_i;
          default: ;
        endcase
      end
      // retire before predicting: a result never leaves on the edge its request enters
      if (out_valid_i && out_ready_i) begin
        if (draws_due.size() == 0) begin
          $error("result with no request outstanding: uniform_fraction %0d, scaled_integer %0d",
                 uniform_fraction_i, scaled_integer_i);
          errs++;
        end else begin
          want = draws_due.pop_front();
          if (uniform_fraction_i !== want.fraction) begin
            $error("uniform_fraction: expected %0d, actual %0d", want.fraction,
                   uniform_fraction_i);
            errs++;
          end
          if (scaled_integer_i !== want.scaled) begin
            $error("scaled_integer: expected %0d, actual %0d", want.scaled, scaled_integer_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) draws_due = {draws_due, next_draw(reseed_i)};
      mismatches_o  <= errs;
      outstanding_o <= draws_due.size();
    end
  end

endmodule

// ===== sim/tb_lagged_fibonacci_uniform_rng_unit.sv =====
`timescale 1ns / 1ps
module tb_lagged_fibonacci_uniform_rng_unit;
  import lfur_pkg::*;

  // Longest legal silence is a table rebuild plus a receiver stall
  localparam int QUIET_LIMIT   = 100000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BURSTS = 9;
  localparam int BURST_DRAWS   = 82;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               reseed_i    = 1'b0;
  logic               out_ready_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [23:0]        uniform_fraction_o;
  logic signed [31:0] scaled_integer_o;

  int send_idle_pct = 13;
  int recv_idle_pct = 56;
  int stall_reqs    = 0;
  int stall_seen    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches;
  int outstanding;

  lagged_fibonacci_uniform_rng_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .reseed_i           (reseed_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .uniform_fraction_o (uniform_fraction_o),
    .scaled_integer_o   (scaled_integer_o)
  );

  lagged_fibonacci_uniform_rng_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .reseed_i           (reseed_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .uniform_fraction_i (uniform_fraction_o),
    .scaled_integer_i   (scaled_integer_o),
    .mismatches_o       (mismatches),
    .outstanding_o      (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      stall_seen  <= 0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen  <= stall_reqs;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves valid high; the caller drops it
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Hold valid across back-to-back requests; drop it only for a gap
  task automatic offer_draw(input logic reseed);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    reseed_i   <= reseed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [14:0] s1, input logic [14:0] s2,
                                input logic [31:0] lo, input logic [31:0] hi);
    logic [16:0] junk_a, junk_b;
    junk_a = 17'($urandom());
    junk_b = 17'($urandom());
    in_valid_i <= 1'b0;
    // wait for the block to drain before touching its registers
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    write_reg(CFG_SEED_FIRST, {junk_a, s1});
    write_reg(CFG_SEED_SECOND, {junk_b, s2});
    write_reg(CFG_RANGE_LOWER, lo);
    write_reg(CFG_RANGE_UPPER, hi);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [14:0] s1, s2;
    logic [31:0] lo, hi;
    int          burst, n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default seeds, widest span; first request rebuilds the table regardless of reseed
    write_reg(CFG_RANGE_LOWER, 32'h8000_0000);
    write_reg(CFG_RANGE_UPPER, 32'h7fff_ffff);
    cfg_valid_i <= 1'b0;
    repeat (4) offer_draw(1'b0);

    // Largest legal seeds, most negative span
    apply_settings(15'd31328, 15'd30081, 32'h7fff_ffff, 32'h8000_0000);
    offer_draw(1'b1);
    repeat (2) offer_draw(1'b0);

    // Illegal seeds fall back to defaults; span of one
    apply_settings(15'd31329, 15'h7fff, 32'd0, 32'd0);
    offer_draw(1'b1);
    repeat (2) offer_draw(1'b0);

    // Zero seeds; empty span
    apply_settings(15'd0, 15'd0, 32'd5, 32'd4);
    offer_draw(1'b1);
    repeat (2) offer_draw(1'b0);

    apply_settings(15'h5555, 15'h2aaa, -32'sd100, 32'sd100);
    offer_draw(1'b1);
    repeat (2) offer_draw(1'b0);

    for (burst = 0; burst < RANDOM_BURSTS; burst++) begin
      if (burst == 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 13;
      end else if (burst == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      s1 = 15'($urandom_range(0, 32767));
      s2 = 15'($urandom_range(0, 32767));
      case ($urandom_range(0, 3))
        0: begin
          lo = $urandom();
          hi = $urandom();
        end
        1: begin
          lo = $urandom_range(0, 2000) - 1000;
          hi = lo + $urandom_range(0, 50);
        end
        2: begin
          lo = '0;
          hi = $urandom_range(1, 1000);
        end
        default: begin
          lo = $urandom();
          hi = lo - $urandom_range(1, 10);
        end
      endcase
      apply_settings(s1, s2, lo, hi);
      for (n = 0; n < BURST_DRAWS; n++) begin
        // stall the receiver mid-burst while requests keep coming
        if (burst == 7 && n == 40) stall_reqs <= stall_reqs + 1;
        offer_draw(n == 0 || $urandom_range(0, 199) == 0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== lagged_fibonacci_uniform_rng_unit.f =====
hdl/lfur_pkg.sv
hdl/lfur_ram.sv
hdl/lfur_ctrl.sv
hdl/lfur_dp.sv
hdl/lagged_fibonacci_uniform_rng_unit.sv
sim/lagged_fibonacci_uniform_rng_checker.sv
sim/tb_lagged_fibonacci_uniform_rng_unit.sv
